@@ rtl/fhte_pkg.sv @@
// ----------------------------------------------------------------------------
// fhte_pkg
// Shared types, constants and the fixed prefix-code table for the text encoder.
// ----------------------------------------------------------------------------
package fhte_pkg;

   // Request commands
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // Character codes that select table rows
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_UPPER_A = 8'd65;
   localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
   localparam logic [7:0] CHAR_LOWER_A = 8'd97;
   localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

   localparam int unsigned CODE_ROWS     = 28;
   localparam logic [4:0]  SPACE_INDEX   = 5'd26;
   localparam logic [4:0]  NEWLINE_INDEX = 5'd27;

   // Code values, right-aligned: a..z, space, newline
   localparam logic [8:0] CODE_BITS [CODE_ROWS] = '{
      9'd9,  9'd42, 9'd28, 9'd0,  9'd12, 9'd11,
      9'd59, 9'd1,  9'd7,  9'd42, 9'd87, 9'd31,
      9'd20, 9'd6,  9'd8,  9'd58, 9'd20, 9'd3,
      9'd4,  9'd11, 9'd30, 9'd11, 9'd4,  9'd86,
      9'd10, 9'd87, 9'd13, 9'd86
   };

   // Code lengths, 4..9
   localparam logic [3:0] CODE_LEN [CODE_ROWS] = '{
      4'd4, 4'd6, 4'd5, 4'd4, 4'd4, 4'd5,
      4'd6, 4'd4, 4'd4, 4'd8, 4'd7, 4'd5,
      4'd5, 4'd4, 4'd4, 4'd6, 4'd7, 4'd4,
      4'd4, 4'd4, 4'd5, 4'd6, 4'd5, 4'd7,
      4'd5, 4'd9, 4'd4, 4'd9
   };

   typedef struct packed {
      logic       hit;
      logic [8:0] bits;
      logic [3:0] len;
   } code_entry_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic [2:0] pad_bits;
   } rsp_item_type;

   // Map a character to its prefix code; hit is low for uncoded characters
   function automatic code_entry_type code_lookup(input logic [7:0] ch);
      code_entry_type entry;
      logic [4:0]     idx;
      entry = '0;
      idx   = '0;
      entry.hit = 1'b1;
      case (ch) inside
         CHAR_SPACE:                   idx = SPACE_INDEX;
         CHAR_NEWLINE:                 idx = NEWLINE_INDEX;
         [CHAR_UPPER_A:CHAR_UPPER_Z]:  idx = 5'(ch - CHAR_UPPER_A);
         [CHAR_LOWER_A:CHAR_LOWER_Z]:  idx = 5'(ch - CHAR_LOWER_A);
         default:                      entry.hit = 1'b0;
      endcase
      if (entry.hit) begin
         entry.bits = CODE_BITS[idx];
         entry.len  = CODE_LEN[idx];
      end
      return entry;
   endfunction

endpackage

@@ rtl/fhte_req_if.sv @@
// ----------------------------------------------------------------------------
// fhte_req_if
// Request channel: one command and character per request.
// ----------------------------------------------------------------------------
interface fhte_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] char_code;

   modport source (output valid, output command, output char_code, input ready);
   modport sink   (input valid, input command, input char_code, output ready);
endinterface

@@ rtl/fhte_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fhte_rsp_if
// Result channel: one packed output byte per transfer.
// ----------------------------------------------------------------------------
interface fhte_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic [2:0] pad_bits;

   modport source (output valid, output out_byte, output last_of_run, output pad_bits,
                   input ready);
   modport sink   (input valid, input out_byte, input last_of_run, input pad_bits,
                   output ready);
endinterface

@@ rtl/fixed_huffman_text_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// fixed_huffman_text_encoder_unit
// Fixed prefix-code text encoder: packs per-character codes into bytes.
// ----------------------------------------------------------------------------
// Latency: first byte of a request is presented the cycle after acceptance.
// Throughput: one request per cycle while each yields at most one byte and the
//   result port is ready; after a character that completes two bytes, requests
//   wait while the two-entry result buffer is full and the one-byte port drains it.
// Reset: synchronous; clears the bit accumulator and empties the result buffer.
// ----------------------------------------------------------------------------
module fixed_huffman_text_encoder_unit (
   input logic          clock,
   input logic          reset,
   fhte_req_if.sink     req_ch,
   fhte_rsp_if.source   rsp_ch
);
   import fhte_pkg::*;

   logic [6:0]      partial_ff, partial_in;
   logic [2:0]      bit_count_ff, bit_count_in;
   logic [1:0]      cnt_ff, cnt_in;
   rsp_item_type    slot0_ff, slot0_in;
   rsp_item_type    slot1_ff, slot1_in;

   logic            req_fire;
   logic            rsp_fire;
   code_entry_type  code;
   logic [15:0]     acc;
   logic [4:0]      total;
   logic [2:0]      shift_amt;
   logic [2:0]      pad;
   logic [1:0]      new_cnt;
   rsp_item_type    new0, new1;
   logic [6:0]      next_partial;
   logic [2:0]      next_count;

   // Handshakes: accept when the buffer is empty or drains its last byte now
   assign rsp_fire     = rsp_ch.valid && rsp_ch.ready;
   assign req_ch.ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Code lookup and bit packing
   assign code      = code_lookup(req_ch.char_code);
   assign acc       = ({9'd0, partial_ff} << code.len) | {7'd0, code.bits};
   assign total     = {2'd0, bit_count_ff} + {1'b0, code.len};
   assign shift_amt = 3'(total - 5'd8);
   assign pad       = 3'(4'd8 - {1'b0, bit_count_ff});

   always_comb begin
      new_cnt      = 2'd0;
      new0         = '0;
      new1         = '0;
      next_partial = partial_ff;
      next_count   = bit_count_ff;
      if (req_ch.command == CMD_FLUSH) begin
         if (bit_count_ff != 3'd0) begin
            new_cnt          = 2'd1;
            new0.out_byte    = 8'({1'b0, partial_ff} << pad);
            new0.last_of_run = 1'b1;
            new0.pad_bits    = pad;
            next_partial     = '0;
            next_count       = '0;
         end
      end else if (code.hit) begin
         if (total >= 5'd16) begin
            // exactly two full bytes, nothing left over
            new_cnt          = 2'd2;
            new0.out_byte    = acc[15:8];
            new1.out_byte    = acc[7:0];
            new1.last_of_run = 1'b1;
            next_partial     = '0;
            next_count       = '0;
         end else if (total >= 5'd8) begin
            new_cnt          = 2'd1;
            new0.out_byte    = 8'(acc >> shift_amt);
            new0.last_of_run = 1'b1;
            next_partial     = 7'(acc & ((16'd1 << shift_amt) - 16'd1));
            next_count       = shift_amt;
         end else begin
            next_partial     = acc[6:0];
            next_count       = total[2:0];
         end
      end
   end

   // Result buffer and accumulator next state
   always_comb begin
      cnt_in       = cnt_ff;
      slot0_in     = slot0_ff;
      slot1_in     = slot1_ff;
      partial_in   = partial_ff;
      bit_count_in = bit_count_ff;
      if (rsp_fire) begin
         cnt_in   = cnt_ff - 2'd1;
         slot0_in = slot1_ff;
      end
      if (req_fire) begin
         cnt_in       = new_cnt;
         slot0_in     = new0;
         slot1_in     = new1;
         partial_in   = next_partial;
         bit_count_in = next_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         partial_ff   <= '0;
         bit_count_ff <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         partial_ff   <= partial_in;
         bit_count_ff <= bit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   // Result port
   assign rsp_ch.valid       = (cnt_ff != 2'd0);
   assign rsp_ch.out_byte    = slot0_ff.out_byte;
   assign rsp_ch.last_of_run = slot0_ff.last_of_run;
   assign rsp_ch.pad_bits    = slot0_ff.pad_bits;

   // Checks
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (cnt_ff != 2'd2))
      else $error("request accepted with full result buffer");

   a_not_last_has_follower: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.last_of_run) |-> (cnt_ff == 2'd2))
      else $error("non-final byte without a queued follower");

   a_pad_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.pad_bits != 3'd0)) |-> rsp_ch.last_of_run)
      else $error("padded byte not marked last");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.command == CMD_FLUSH)) |=> (bit_count_ff == 3'd0))
      else $error("flush left pending bits");

   a_uncoded_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_ch.command == CMD_ENCODE) && !code.hit)
         |=> ($stable(bit_count_ff) && $stable(partial_ff)))
      else $error("uncoded character changed the accumulator");

endmodule
